/* src/rad_pkg.sv */
// Shared types and constants for the rectangle attraction direction block.
// Used by rad_sqrt_cell, rad_div_cell and rect_attraction_direction_top.
package rad_pkg;

  localparam int COORD_W   = 20;
  localparam int SIZE_W    = 19;
  localparam int DIR_W     = 16;
  localparam int MAG_W     = 21;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int SUM_W     = SQ_W + 1;
  localparam int GUARD     = 9;
  localparam int RAD_W     = 62;
  localparam int ROOT_W    = RAD_W / 2;
  localparam int REM_W     = ROOT_W + 2;
  localparam int Q_W       = 15;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int DIV_STEPS  = Q_W;

  // Register indexes
  localparam logic [1:0] REG_LEFT   = 2'd0;
  localparam logic [1:0] REG_TOP    = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  localparam logic [DIR_W-1:0] DIR_POS_ONE = 16'sh4000;
  localparam logic [DIR_W-1:0] DIR_NEG_ONE = 16'shC000;

  typedef struct packed {
    logic             diag;
    logic             neg_x;
    logic             neg_y;
    logic [DIR_W-1:0] dflt_x;
    logic [DIR_W-1:0] dflt_y;
    logic [MAG_W-1:0] mag_x;
    logic [MAG_W-1:0] mag_y;
  } rad_meta_t;

  typedef struct packed {
    rad_meta_t         meta;
    logic [RAD_W-1:0]  rad;
    logic [ROOT_W-1:0] root;
    logic [REM_W-2:0]  rem;
  } rad_sqrt_t;

  typedef struct packed {
    rad_meta_t         meta;
    logic [ROOT_W-1:0] dvsr;
    logic [ROOT_W-1:0] rem_x;
    logic [ROOT_W-1:0] rem_y;
    logic [Q_W-1:0]    q_x;
    logic [Q_W-1:0]    q_y;
  } rad_div_t;

endpackage

/* src/rad_sqrt_cell.sv */
// One digit step of the restoring square root chain.
// Depends on rad_pkg.
module rad_sqrt_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  rad_pkg::rad_sqrt_t in_data,
  output logic               out_vld_r,
  output rad_pkg::rad_sqrt_t out_data_r
);

  logic [rad_pkg::REM_W:0]   cat;
  logic [rad_pkg::REM_W:0]   trial;
  logic [rad_pkg::REM_W:0]   diff;
  logic                      ge;
  rad_pkg::rad_sqrt_t        data_nxt;

  // Bring down two radicand bits and try the next root digit
  always_comb begin
    cat   = {in_data.rem, in_data.rad[rad_pkg::RAD_W-1 -: 2]};
    trial = {1'b0, in_data.root, 2'b01};
    ge    = (cat >= trial);
    diff  = cat - trial;
    data_nxt      = in_data;
    data_nxt.rad  = {in_data.rad[rad_pkg::RAD_W-3:0], 2'b00};
    data_nxt.root = {in_data.root[rad_pkg::ROOT_W-2:0], ge};
    data_nxt.rem  = ge ? diff[rad_pkg::REM_W-2:0] : cat[rad_pkg::REM_W-2:0];
  end

  // Advance the valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= in_vld;
    end
  end

  // Hand the item to the next cell
  always_ff @(posedge clk) begin
    out_data_r <= data_nxt;
  end

endmodule

/* src/rad_div_cell.sv */
// One quotient bit step of the two parallel restoring dividers.
// Depends on rad_pkg.
module rad_div_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  rad_pkg::rad_div_t in_data,
  output logic              out_vld_r,
  output rad_pkg::rad_div_t out_data_r
);

  logic [rad_pkg::ROOT_W:0] tx;
  logic [rad_pkg::ROOT_W:0] ty;
  logic [rad_pkg::ROOT_W:0] dv;
  logic [rad_pkg::ROOT_W:0] sx;
  logic [rad_pkg::ROOT_W:0] sy;
  logic                     gx;
  logic                     gy;
  rad_pkg::rad_div_t        data_nxt;

  // Shift the partial remainders and subtract the norm where it fits
  always_comb begin
    tx = {in_data.rem_x, 1'b0};
    ty = {in_data.rem_y, 1'b0};
    dv = {1'b0, in_data.dvsr};
    gx = (tx >= dv);
    gy = (ty >= dv);
    sx = tx - dv;
    sy = ty - dv;
    data_nxt       = in_data;
    data_nxt.rem_x = gx ? sx[rad_pkg::ROOT_W-1:0] : tx[rad_pkg::ROOT_W-1:0];
    data_nxt.rem_y = gy ? sy[rad_pkg::ROOT_W-1:0] : ty[rad_pkg::ROOT_W-1:0];
    data_nxt.q_x   = {in_data.q_x[rad_pkg::Q_W-2:0], gx};
    data_nxt.q_y   = {in_data.q_y[rad_pkg::Q_W-2:0], gy};
  end

  // Advance the valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= in_vld;
    end
  end

  // Hand the item to the next cell
  always_ff @(posedge clk) begin
    out_data_r <= data_nxt;
  end

endmodule

/* src/rect_attraction_direction_top.sv */
// Rectangle attraction direction: region classify, squared distance,
// a 31-cell square root chain and a 15-cell divider chain.
// Throughput: one item per cycle, set by the fully pipelined cell chains;
// busy is always low. Reset (synchronous, rst_n low) clears the rectangle
// registers and the valid flags to zero, which empties the pipeline; the
// receiver cannot stall, so results are never held.
// Depends on rad_pkg, rad_sqrt_cell, rad_div_cell.
module rect_attraction_direction_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [19:0] cfg_wdata,
  input  logic        start,
  output logic        busy,
  input  logic [19:0] in_pos_x,
  input  logic [19:0] in_pos_y,
  output logic        out_valid,
  output logic [15:0] out_dir_x,
  output logic [15:0] out_dir_y
);

  logic [rad_pkg::COORD_W-1:0] left_r;
  logic [rad_pkg::COORD_W-1:0] top_r;
  logic [rad_pkg::SIZE_W-1:0]  width_r;
  logic [rad_pkg::SIZE_W-1:0]  height_r;

  assign busy = 1'b0;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      top_r    <= '0;
      width_r  <= '0;
      height_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        rad_pkg::REG_LEFT:   left_r   <= cfg_wdata;
        rad_pkg::REG_TOP:    top_r    <= cfg_wdata;
        rad_pkg::REG_WIDTH:  width_r  <= cfg_wdata[rad_pkg::SIZE_W-1:0];
        rad_pkg::REG_HEIGHT: height_r <= cfg_wdata[rad_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage 0: classify the point and take corner offsets
  logic signed [20:0] px, py, lft, tp, rgt, bot, cx, cy;
  logic signed [21:0] dx, dy;
  logic               above, below, lof, rof;
  rad_pkg::rad_meta_t meta0_nxt;

  always_comb begin
    px  = {in_pos_x[19], in_pos_x};
    py  = {in_pos_y[19], in_pos_y};
    lft = {left_r[19], left_r};
    tp  = {top_r[19], top_r};
    rgt = lft + $signed({2'b00, width_r});
    bot = tp + $signed({2'b00, height_r});
    above = (py < tp);
    below = (py > bot);
    lof   = (px < lft);
    rof   = (px > rgt);
    cx = lof ? lft : rgt;
    cy = above ? tp : bot;
    dx = {cx[20], cx} - {px[20], px};
    dy = {cy[20], cy} - {py[20], py};
    meta0_nxt.diag   = (above || below) && (lof || rof);
    meta0_nxt.neg_x  = dx[21];
    meta0_nxt.neg_y  = dy[21];
    meta0_nxt.mag_x  = dx[21] ? 21'(-dx) : dx[20:0];
    meta0_nxt.mag_y  = dy[21] ? 21'(-dy) : dy[20:0];
    meta0_nxt.dflt_x = '0;
    meta0_nxt.dflt_y = '0;
    if (above) begin
      meta0_nxt.dflt_y = rad_pkg::DIR_POS_ONE;
    end else if (below) begin
      meta0_nxt.dflt_y = rad_pkg::DIR_NEG_ONE;
    end else if (lof) begin
      meta0_nxt.dflt_x = rad_pkg::DIR_POS_ONE;
    end else if (rof) begin
      meta0_nxt.dflt_x = rad_pkg::DIR_NEG_ONE;
    end
  end

  logic               vld0_r, vld1_r, vld2_r;
  rad_pkg::rad_meta_t meta0_r, meta1_r;
  logic [rad_pkg::SQ_W-1:0] sqx_r, sqy_r;
  rad_pkg::rad_sqrt_t sq_init_r;
  logic [rad_pkg::SUM_W-1:0] sum;

  always_comb begin
    sum = {1'b0, sqx_r} + {1'b0, sqy_r};
  end

  // Stages 0 to 2 valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld0_r <= start;
      vld1_r <= vld0_r;
      vld2_r <= vld1_r;
    end
  end

  // Square the offsets, then sum and load the root chain
  always_ff @(posedge clk) begin
    meta0_r <= meta0_nxt;
    meta1_r <= meta0_r;
    sqx_r   <= meta0_r.mag_x * meta0_r.mag_x;
    sqy_r   <= meta0_r.mag_y * meta0_r.mag_y;
    sq_init_r.meta <= meta1_r;
    sq_init_r.rad  <= {1'b0, sum, 18'b0};
    sq_init_r.root <= '0;
    sq_init_r.rem  <= '0;
  end

  // Square root chain
  logic               sq_vld [rad_pkg::SQRT_STEPS+1];
  rad_pkg::rad_sqrt_t sq_dat [rad_pkg::SQRT_STEPS+1];

  assign sq_vld[0] = vld2_r;
  assign sq_dat[0] = sq_init_r;

  for (genvar i = 0; i < rad_pkg::SQRT_STEPS; i++) begin : g_sqrt
    rad_sqrt_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .in_vld     (sq_vld[i]),
      .in_data    (sq_dat[i]),
      .out_vld_r  (sq_vld[i+1]),
      .out_data_r (sq_dat[i+1])
    );
  end

  // Load the divider chain: numerator magnitude shifted left by eight bits
  logic             dv_vld [rad_pkg::DIV_STEPS+1];
  rad_pkg::rad_div_t dv_dat [rad_pkg::DIV_STEPS+1];
  rad_pkg::rad_sqrt_t sq_last;

  always_comb begin
    sq_last = sq_dat[rad_pkg::SQRT_STEPS];
    dv_dat[0].meta  = sq_last.meta;
    dv_dat[0].dvsr  = sq_last.root;
    dv_dat[0].rem_x = {2'b00, sq_last.meta.mag_x, 8'b0};
    dv_dat[0].rem_y = {2'b00, sq_last.meta.mag_y, 8'b0};
    dv_dat[0].q_x   = '0;
    dv_dat[0].q_y   = '0;
  end
  assign dv_vld[0] = sq_vld[rad_pkg::SQRT_STEPS];

  for (genvar j = 0; j < rad_pkg::DIV_STEPS; j++) begin : g_div
    rad_div_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .in_vld     (dv_vld[j]),
      .in_data    (dv_dat[j]),
      .out_vld_r  (dv_vld[j+1]),
      .out_data_r (dv_dat[j+1])
    );
  end

  // Apply signs and pick the result
  rad_pkg::rad_div_t dv_last;
  logic [15:0]       dir_x_nxt, dir_y_nxt, qx, qy;

  always_comb begin
    dv_last = dv_dat[rad_pkg::DIV_STEPS];
    qx = {1'b0, dv_last.q_x};
    qy = {1'b0, dv_last.q_y};
    if (!dv_last.meta.diag) begin
      dir_x_nxt = dv_last.meta.dflt_x;
      dir_y_nxt = dv_last.meta.dflt_y;
    end else if (dv_last.dvsr == '0) begin
      dir_x_nxt = '0;
      dir_y_nxt = '0;
    end else begin
      dir_x_nxt = dv_last.meta.neg_x ? 16'(-qx) : qx;
      dir_y_nxt = dv_last.meta.neg_y ? 16'(-qy) : qy;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dv_vld[rad_pkg::DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    out_dir_x <= dir_x_nxt;
    out_dir_y <= dir_y_nxt;
  end

endmodule

/* verif/tb_top.sv */
// Testbench for rect_attraction_direction_top: drives point queries and
// rectangle registers, predicts each direction and checks the results.
// Depends on rad_pkg and the rect_attraction_direction_top RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ONE = 1 << 14;
  localparam int TAIL_CYCLES = 80;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [19:0] cfg_wdata;
  logic        start;
  logic        busy;
  logic [19:0] in_pos_x;
  logic [19:0] in_pos_y;
  logic        out_valid;
  logic [15:0] out_dir_x;
  logic [15:0] out_dir_y;

  typedef struct packed {
    logic [15:0] dx;
    logic [15:0] dy;
  } dir_t;

  dir_t dir_queue[$];
  int   err_cnt = 0;
  int   sent_cnt = 0;
  int   got_cnt = 0;
  int   diag_cnt = 0;
  int   idle_pct = 0;

  // Predictor copy of the rectangle registers
  longint rl = 0, rt = 0, rw = 0, rh = 0;

  rect_attraction_direction_top dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata), .start(start), .busy(busy),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .out_valid(out_valid),
    .out_dir_x(out_dir_x), .out_dir_y(out_dir_y)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Verification failed");
    $finish;
  end

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Unit vector toward a corner, norm carries nine guard bits
  function automatic dir_t corner_dir(longint cx, longint cy, longint px, longint py);
    longint d_x, d_y, ax, ay, r, qx, qy;
    dir_t res;
    d_x = cx - px;
    d_y = cy - py;
    ax = d_x < 0 ? -d_x : d_x;
    ay = d_y < 0 ? -d_y : d_y;
    r = int_sqrt((ax * ax + ay * ay) << 18);
    if (r == 0) return '0;
    qx = (ax << 23) / r;
    qy = (ay << 23) / r;
    res.dx = 16'(d_x < 0 ? -qx : qx);
    res.dy = 16'(d_y < 0 ? -qy : qy);
    return res;
  endfunction

  function automatic dir_t attraction_dir(logic [19:0] xr, logic [19:0] yr);
    longint px, py, rgt, bot;
    dir_t res;
    px = longint'(signed'(xr));
    py = longint'(signed'(yr));
    rgt = rl + rw;
    bot = rt + rh;
    res = '0;
    if (py < rt) begin
      res.dy = 16'(ONE);
      if (px < rl) res = corner_dir(rl, rt, px, py);
      else if (px > rgt) res = corner_dir(rgt, rt, px, py);
    end else if (py > bot) begin
      res.dy = 16'(-ONE);
      if (px < rl) res = corner_dir(rl, bot, px, py);
      else if (px > rgt) res = corner_dir(rgt, bot, px, py);
    end else if (px < rl) begin
      res.dx = 16'(ONE);
    end else if (px > rgt) begin
      res.dx = 16'(-ONE);
    end
    if ((py < rt || py > bot) && (px < rl || px > rgt)) diag_cnt++;
    return res;
  endfunction

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    dir_t exp_d;
    if (rst_n && out_valid) begin
      got_cnt++;
      if (dir_queue.size() == 0) begin
        $display("%0t: unexpected result dir=(%h,%h)", $time, out_dir_x, out_dir_y);
        err_cnt++;
      end else begin
        exp_d = dir_queue.pop_front();
        if (out_dir_x !== exp_d.dx) begin
          $display("%0t: dir_x expected %h actual %h", $time, exp_d.dx, out_dir_x);
          err_cnt++;
        end
        if (out_dir_y !== exp_d.dy) begin
          $display("%0t: dir_y expected %h actual %h", $time, exp_d.dy, out_dir_y);
          err_cnt++;
        end
      end
    end
  end

  // Send one point, with a random idle gap first; start stays high for back to back items
  task automatic send_point(logic [19:0] x, logic [19:0] y);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_pos_x <= x;
    in_pos_y <= y;
    dir_queue.push_back(attraction_dir(x, y));
    sent_cnt++;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drop start and wait until every item has come out
  task automatic wait_drain();
    int guard;
    guard = 0;
    start <= 1'b0;
    while (dir_queue.size() != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Write the rectangle once the pipeline is empty
  task automatic set_rect(longint l, longint t, longint w, longint h);
    wait_drain();
    cfg_we <= 1'b1;
    cfg_addr <= rad_pkg::REG_LEFT;   cfg_wdata <= 20'(l); @(posedge clk);
    cfg_addr <= rad_pkg::REG_TOP;    cfg_wdata <= 20'(t); @(posedge clk);
    cfg_addr <= rad_pkg::REG_WIDTH;  cfg_wdata <= 20'(w); @(posedge clk);
    cfg_addr <= rad_pkg::REG_HEIGHT; cfg_wdata <= 20'(h); @(posedge clk);
    cfg_we <= 1'b0;
    rl = l; rt = t; rw = w; rh = h;
    @(posedge clk);
  endtask

  task automatic test_directed();
    longint xs[5], ys[5];
    set_rect(-160, -320, 640, 480);
    xs = '{-524288, -161, -160, 480, 524287};
    ys = '{-524288, -321, -320, 160, 524287};
    foreach (xs[i]) foreach (ys[j]) send_point(20'(xs[i]), 20'(ys[j]));
  endtask

  task automatic test_extremes();
    set_rect(-524288, -524288, 524287, 524287);
    send_point(20'h7FFFF, 20'h7FFFF);
    send_point(20'h00000, 20'h7FFFF);
    send_point(20'h7FFFF, 20'h00000);
    set_rect(524287, 524287, 524287, 524287);
    send_point(20'h80000, 20'h80000);
    send_point(20'h80000, 20'h7FFFF);
    // Degenerate rectangle: a single point
    set_rect(0, 0, 0, 0);
    send_point(20'd0, 20'd0);
    send_point(20'h7FFFF, 20'h80000);
    send_point(20'hFFFFF, 20'd1);
  endtask

  // Random points near the rectangle, some across the full range
  task automatic test_random(int n, int pct);
    longint l, t, w, h;
    logic [19:0] x, y;
    l = $signed(20'($urandom));
    t = $signed(20'($urandom));
    w = $urandom_range(3) == 0 ? $urandom_range(524287) : $urandom_range(400);
    h = $urandom_range(3) == 0 ? $urandom_range(524287) : $urandom_range(400);
    set_rect(l, t, w, h);
    idle_pct = pct;
    repeat (n) begin
      if ($urandom_range(3) == 0) begin
        x = 20'($urandom);
        y = 20'($urandom);
      end else begin
        x = 20'(l + longint'($urandom_range(w + 200)) - 100);
        y = 20'(t + longint'($urandom_range(h + 200)) - 100);
      end
      send_point(x, y);
    end
    idle_pct = 0;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = rad_pkg::REG_LEFT;
    cfg_wdata = '0;
    start = 1'b0;
    in_pos_x = '0;
    in_pos_y = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_point(20'd5, 20'hFFFFB);
    test_directed();
    test_extremes();
    for (int p = 0; p < 8; p++) test_random(90, p % 4 == 0 ? 0 : (p % 2 ? 56 : 32));
    wait_drain();
    $display("Covered %0d points (%0d diagonal) over 12 rectangles, %0d results checked.",
             sent_cnt, diag_cnt, got_cnt);
    if (err_cnt == 0 && dir_queue.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

/* files.f */
src/rad_pkg.sv
src/rad_sqrt_cell.sv
src/rad_div_cell.sv
src/rect_attraction_direction_top.sv
verif/tb_top.sv
